// ===== design/hpi_pkg.sv =====
`timescale 1ns / 1ps

package hpi_pkg;

  // Stages from input register to output register.
  localparam int NUM_STAGES = 5;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TENSION = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIAS    = 2'd1;

  // Per-stage load enables, shared by every datapath slice.
  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } hpi_ctrl_t;

endpackage

// ===== design/hpi_round.sv =====
`timescale 1ns / 1ps

// Drops SHIFT fraction bits of a signed value, rounding to nearest with ties
// away from zero.
module hpi_round #(
  parameter int IN_W  = 40,
  parameter int SHIFT = 16,
  parameter int OUT_W = 24
) (
  input  logic signed [IN_W-1:0]  din,
  output logic signed [OUT_W-1:0] dout
);

  localparam logic [IN_W:0] HALF = (IN_W+1)'(1) << (SHIFT - 1);

  logic signed [IN_W:0] biased;

  // Negative values take one less so that ties move away from zero.
  assign biased = {din[IN_W-1], din} + HALF - {{IN_W{1'b0}}, din[IN_W-1]};
  assign dout   = OUT_W'(biased >>> SHIFT);

endmodule

// ===== design/hpi_weights.sv =====
`timescale 1ns / 1ps

module hpi_weights
  import hpi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FRAC_BITS+1:0]      cfg_data,
  output logic [FRAC_BITS+1:0]      aa,
  output logic [FRAC_BITS+1:0]      bb
);

  localparam int RW = FRAC_BITS + 2;
  localparam int PW = 2 * FRAC_BITS + 4;
  localparam logic signed [RW-1:0] ONE_Q     = RW'(1) << FRAC_BITS;
  localparam logic signed [RW-1:0] NEG_ONE_Q = -ONE_Q;
  localparam logic signed [RW:0]   ONE_W     = (RW+1)'(1) << FRAC_BITS;
  localparam logic [PW-1:0]        HALF      = PW'(1) << FRAC_BITS;
  localparam logic [RW-1:0]        AA_RESET  = RW'(1) << (FRAC_BITS - 1);

  logic signed [RW-1:0] tension;
  logic signed [RW-1:0] bias;
  logic signed [RW-1:0] wdata;
  logic signed [RW-1:0] wclamp;
  logic signed [RW:0]   opb_s;
  logic signed [RW:0]   omb_s;
  logic signed [RW:0]   omt_s;
  logic [PW-1:0]        aa_prod;
  logic [PW-1:0]        bb_prod;
  logic [RW-1:0]        aa_next;
  logic [RW-1:0]        bb_next;

  // Registers hold the value already limited to -1.0 .. 1.0.
  assign wdata  = signed'(cfg_data);
  assign wclamp = (wdata > ONE_Q) ? ONE_Q : ((wdata < NEG_ONE_Q) ? NEG_ONE_Q : wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= '0;
      bias    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TENSION: tension <= wclamp;
        REG_BIAS:    bias    <= wclamp;
        default: ;
      endcase
    end
  end

  // All three factors lie in 0 .. 2.0, so the products are unsigned.
  assign opb_s   = ONE_W + {bias[RW-1], bias};
  assign omb_s   = ONE_W - {bias[RW-1], bias};
  assign omt_s   = ONE_W - {tension[RW-1], tension};
  assign aa_prod = PW'(opb_s[RW-1:0]) * PW'(omt_s[RW-1:0]);
  assign bb_prod = PW'(omb_s[RW-1:0]) * PW'(omt_s[RW-1:0]);
  assign aa_next = RW'((aa_prod + HALF) >> (FRAC_BITS + 1));
  assign bb_next = RW'((bb_prod + HALF) >> (FRAC_BITS + 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      aa <= AA_RESET;
      bb <= AA_RESET;
    end else begin
      aa <= aa_next;
      bb <= bb_next;
    end
  end

endmodule

// ===== design/hpi_basis.sv =====
`timescale 1ns / 1ps

// Powers of t and the four Hermite basis weights, three stages deep.
module hpi_basis
  import hpi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  hpi_ctrl_t                   ctrl,
  input  logic [FRAC_BITS:0]          t_value,
  output logic signed [FRAC_BITS+3:0] u0,
  output logic signed [FRAC_BITS+3:0] u1,
  output logic signed [FRAC_BITS+3:0] u2,
  output logic signed [FRAC_BITS+3:0] u3
);

  localparam int TW = FRAC_BITS + 1;
  localparam int SW = 2 * FRAC_BITS + 2;
  localparam int UW = FRAC_BITS + 4;
  localparam logic [TW-1:0]        ONE_T = TW'(1) << FRAC_BITS;
  localparam logic [SW:0]          HALF  = (SW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;

  logic [TW-1:0] tc_next;
  logic [SW-1:0] tsq_next;
  logic [TW-1:0] tc_0;
  logic [SW-1:0] tsq_0;

  logic [SW:0]   tsq_rnd;
  logic [TW-1:0] t2_next;
  logic [SW-1:0] tcu_next;
  logic [TW-1:0] t_1;
  logic [TW-1:0] t2_1;
  logic [SW-1:0] tcu_1;

  logic [SW:0]          tcu_rnd;
  logic signed [UW-1:0] ts;
  logic signed [UW-1:0] t2s;
  logic signed [UW-1:0] t3s;

  assign tc_next  = (t_value > ONE_T) ? ONE_T : t_value;
  assign tsq_next = SW'(tc_next) * SW'(tc_next);

  // Products of nonnegative values: rounding is a plain add of one half.
  assign tsq_rnd  = (SW+1)'(tsq_0) + HALF;
  assign t2_next  = TW'(tsq_rnd >> FRAC_BITS);
  assign tcu_next = SW'(tc_0) * SW'(t2_next);

  assign tcu_rnd = (SW+1)'(tcu_1) + HALF;
  assign ts      = signed'(UW'(t_1));
  assign t2s     = signed'(UW'(t2_1));
  assign t3s     = signed'(UW'(tcu_rnd >> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      tc_0  <= tc_next;
      tsq_0 <= tsq_next;
    end
    if (ctrl.adv[1]) begin
      t_1   <= tc_0;
      t2_1  <= t2_next;
      tcu_1 <= tcu_next;
    end
    if (ctrl.adv[2]) begin
      u0 <= (t3s <<< 1) - (t2s + (t2s <<< 1)) + ONE_U;
      u1 <= t3s - (t2s <<< 1) + ts;
      u2 <= t3s - t2s;
      u3 <= (t2s + (t2s <<< 1)) - (t3s <<< 1);
    end
  end

endmodule

// ===== design/hpi_coord.sv =====
`timescale 1ns / 1ps

// One coordinate: differences, tangents, weighted sum and saturation.
module hpi_coord
  import hpi_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  hpi_ctrl_t                    ctrl,
  input  logic [FRAC_BITS+1:0]         aa,
  input  logic [FRAC_BITS+1:0]         bb,
  input  logic signed [FRAC_BITS+3:0]  u0,
  input  logic signed [FRAC_BITS+3:0]  u1,
  input  logic signed [FRAC_BITS+3:0]  u2,
  input  logic signed [FRAC_BITS+3:0]  u3,
  input  logic signed [COORD_BITS-1:0] p0,
  input  logic signed [COORD_BITS-1:0] p1,
  input  logic signed [COORD_BITS-1:0] p2,
  input  logic signed [COORD_BITS-1:0] p3,
  output logic signed [COORD_BITS-1:0] value,
  output logic                         sat
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int TPW = CW + FRAC_BITS + 4;
  localparam int MW  = CW + 4;
  localparam int RPW = CW + FRAC_BITS + 8;
  localparam int RW  = CW + 8;
  localparam int SW  = CW + 10;
  localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] MAX_S = SW'(MAX_C);
  localparam logic signed [SW-1:0] MIN_S = SW'(MIN_C);

  logic signed [DW-1:0] d01_next, d12_next, d23_next;
  logic signed [DW-1:0] d01_0, d12_0, d23_0;
  logic signed [CW-1:0] p1_0, p2_0, p1_1, p2_1, p1_2, p2_2;

  logic signed [FRAC_BITS+2:0] aa_s, bb_s;
  logic signed [TPW-1:0]       tp_next [4];
  logic signed [TPW-1:0]       tp_1    [4];
  logic signed [MW-1:0]        tr      [4];
  logic signed [MW-1:0]        m0_2, m1_2;

  logic signed [RPW-1:0] rp_next [4];
  logic signed [RPW-1:0] rp_3    [4];
  logic signed [RW-1:0]  rr      [4];
  logic signed [SW-1:0]  sum;

  assign d01_next = p1 - p0;
  assign d12_next = p2 - p1;
  assign d23_next = p3 - p2;

  assign aa_s = signed'({1'b0, aa});
  assign bb_s = signed'({1'b0, bb});

  // Tangent terms: aa*(p1-p0), bb*(p2-p1) for m0 and aa*(p2-p1), bb*(p3-p2) for m1.
  assign tp_next[0] = aa_s * d01_0;
  assign tp_next[1] = bb_s * d12_0;
  assign tp_next[2] = aa_s * d12_0;
  assign tp_next[3] = bb_s * d23_0;

  assign rp_next[0] = u0 * p1_2;
  assign rp_next[1] = u1 * m0_2;
  assign rp_next[2] = u2 * m1_2;
  assign rp_next[3] = u3 * p2_2;

  for (genvar i = 0; i < 4; i++) begin : g_round
    hpi_round #(.IN_W(TPW), .SHIFT(FRAC_BITS), .OUT_W(MW)) u_tan_round (
      .din  (tp_1[i]),
      .dout (tr[i])
    );
    hpi_round #(.IN_W(RPW), .SHIFT(FRAC_BITS), .OUT_W(RW)) u_term_round (
      .din  (rp_3[i]),
      .dout (rr[i])
    );
  end

  assign sum = SW'(rr[0]) + SW'(rr[1]) + SW'(rr[2]) + SW'(rr[3]);

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      p1_0  <= p1;
      p2_0  <= p2;
      d01_0 <= d01_next;
      d12_0 <= d12_next;
      d23_0 <= d23_next;
    end
    if (ctrl.adv[1]) begin
      p1_1 <= p1_0;
      p2_1 <= p2_0;
      tp_1 <= tp_next;
    end
    if (ctrl.adv[2]) begin
      p1_2 <= p1_1;
      p2_2 <= p2_1;
      m0_2 <= tr[0] + tr[1];
      m1_2 <= tr[2] + tr[3];
    end
    if (ctrl.adv[3]) begin
      rp_3 <= rp_next;
    end
    if (ctrl.adv[4]) begin
      if (sum > MAX_S) begin
        value <= MAX_C;
        sat   <= 1'b1;
      end else if (sum < MIN_S) begin
        value <= MIN_C;
        sat   <= 1'b1;
      end else begin
        value <= CW'(sum);
        sat   <= 1'b0;
      end
    end
  end

endmodule

// ===== design/hermite_point_interpolator.sv =====
`timescale 1ns / 1ps

// Cubic Hermite interpolation of a 2-D point between p1 and p2, with
// tension and bias. Coordinates are signed with FRAC_BITS fraction bits.
//
// Input channel (in_valid / in_stall): one word carries t_value and the
// four control points. Output channel (out_valid / out_stall): one word
// carries out_x, out_y and the saturated flag for each input word.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// writes tension, index 1 writes bias; other indexes are ignored. cfg_ready
// is always high. Write only while no word is in flight.
//
// Five stages: differences and t^2 product, tangent and t^3 products,
// basis and tangent sums, term products, final sum with saturation. One
// word is accepted every cycle while in_stall is low. When the receiver
// stalls, the output word holds and empty stages behind it keep filling;
// in_stall rises only once the stage at the input is occupied and cannot
// move on. Reset clears all stages and sets tension and bias to zero;
// in_stall is high while rst is asserted.
module hermite_point_interpolator
  import hpi_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [FRAC_BITS+1:0]         cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [FRAC_BITS:0]           t_value,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p3_x,
  input  logic signed [COORD_BITS-1:0] p3_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         saturated
);

  localparam logic signed [COORD_BITS-1:0] MAX_C = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MIN_C = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [NUM_STAGES-1:0]       valid;
  hpi_ctrl_t                   ctrl;
  logic [FRAC_BITS+1:0]        aa, bb;
  logic signed [FRAC_BITS+3:0] u0, u1, u2, u3;
  logic                        sat_x, sat_y;

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    ctrl.adv[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctrl.adv[i] = !valid[i] || ctrl.adv[i+1];
    end
  end

  assign in_stall  = rst || !ctrl.adv[0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ctrl.adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  hpi_weights #(.FRAC_BITS(FRAC_BITS)) u_weights (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .aa        (aa),
    .bb        (bb)
  );

  hpi_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
    .clk     (clk),
    .ctrl    (ctrl),
    .t_value (t_value),
    .u0      (u0),
    .u1      (u1),
    .u2      (u2),
    .u3      (u3)
  );

  hpi_coord #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_coord_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .aa    (aa),
    .bb    (bb),
    .u0    (u0),
    .u1    (u1),
    .u2    (u2),
    .u3    (u3),
    .p0    (p0_x),
    .p1    (p1_x),
    .p2    (p2_x),
    .p3    (p3_x),
    .value (out_x),
    .sat   (sat_x)
  );

  hpi_coord #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_coord_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .aa    (aa),
    .bb    (bb),
    .u0    (u0),
    .u1    (u1),
    .u2    (u2),
    .u3    (u3),
    .p0    (p0_y),
    .p1    (p1_y),
    .p2    (p2_y),
    .p3    (p3_y),
    .value (out_y),
    .sat   (sat_y)
  );

  assign out_valid = valid[NUM_STAGES-1];
  assign saturated = sat_x || sat_y;

  // An empty input stage must never push back.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !valid[0] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // A word that moves from the first stage lands in the second.
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    valid[0] && ctrl.adv[1] |=> valid[1])
    else $error("word lost between the first two stages");

  // A blocked stage keeps its word.
  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    valid[3] && !ctrl.adv[4] |=> valid[3])
    else $error("word dropped from a blocked stage");

  // A saturated result sits at a limit of the coordinate range.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == MAX_C || out_x == MIN_C || out_y == MAX_C || out_y == MIN_C))
    else $error("saturation flag without a clipped coordinate");

endmodule

// ===== verif/hermite_point_interpolator_checker.sv =====
`timescale 1ns / 1ps

module hermite_point_interpolator_checker
  import hpi_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [FRAC_BITS+1:0]         cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [FRAC_BITS:0]           t_value,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p3_x,
  input  logic signed [COORD_BITS-1:0] p3_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [COORD_BITS-1:0] out_x,
  input  logic signed [COORD_BITS-1:0] out_y,
  input  logic                         saturated,
  output int unsigned                  pending,
  output int unsigned                  mismatches
);

  localparam longint ONE_Q    = longint'(1) << FRAC_BITS;
  localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         sat;
  } point_result_t;

  point_result_t        expected_points[$];
  logic [FRAC_BITS+1:0] tension_q;
  logic [FRAC_BITS+1:0] bias_q;

  // Weight times value, scaled down by the fraction bits, ties away from zero.
  function automatic longint scale_round(input longint w, input longint v);
    longint prod;
    longint mag;
    prod = w * v;
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (ONE_Q >>> 1)) >>> FRAC_BITS;
    return (prod < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_weight(input logic [FRAC_BITS+1:0] raw);
    longint w;
    w = longint'($signed(raw));
    if (w > ONE_Q) w = ONE_Q;
    else if (w < -ONE_Q) w = -ONE_Q;
    return w;
  endfunction

  function automatic longint blend_axis(input longint u0, input longint u1,
                                        input longint u2, input longint u3,
                                        input longint aa, input longint bb,
                                        input longint c0, input longint c1,
                                        input longint c2, input longint c3,
                                        output bit clipped);
    longint m0;
    longint m1;
    longint s;
    m0 = scale_round(aa, c1 - c0) + scale_round(bb, c2 - c1);
    m1 = scale_round(aa, c2 - c1) + scale_round(bb, c3 - c2);
    s = scale_round(u0, c1) + scale_round(u1, m0) + scale_round(u2, m1)
      + scale_round(u3, c2);
    clipped = (s > COORD_HI) || (s < COORD_LO);
    if (s > COORD_HI) s = COORD_HI;
    else if (s < COORD_LO) s = COORD_LO;
    return s;
  endfunction

  function automatic point_result_t predict_point(
      input logic [FRAC_BITS:0] t_raw,
      input logic [FRAC_BITS+1:0] ten_raw, input logic [FRAC_BITS+1:0] bias_raw,
      input longint ax0, input longint ay0, input longint ax1, input longint ay1,
      input longint ax2, input longint ay2, input longint ax3, input longint ay3);
    point_result_t res;
    longint t, t2, t3, ten, bia, aa, bb, u0, u1, u2, u3, rx, ry;
    bit clip_x;
    bit clip_y;
    t = longint'(t_raw);
    if (t > ONE_Q) t = ONE_Q;
    ten = clamp_weight(ten_raw);
    bia = clamp_weight(bias_raw);
    t2 = scale_round(t, t);
    t3 = scale_round(t, t2);
    u0 = 2 * t3 - 3 * t2 + ONE_Q;
    u1 = t3 - 2 * t2 + t;
    u2 = t3 - t2;
    u3 = -2 * t3 + 3 * t2;
    // Both factors are nonnegative, so adding half before the shift rounds.
    aa = ((ONE_Q + bia) * (ONE_Q - ten) + ONE_Q) >>> (FRAC_BITS + 1);
    bb = ((ONE_Q - bia) * (ONE_Q - ten) + ONE_Q) >>> (FRAC_BITS + 1);
    rx = blend_axis(u0, u1, u2, u3, aa, bb, ax0, ax1, ax2, ax3, clip_x);
    ry = blend_axis(u0, u1, u2, u3, aa, bb, ay0, ay1, ay2, ay3, clip_y);
    res.x = rx[COORD_BITS-1:0];
    res.y = ry[COORD_BITS-1:0];
    res.sat = clip_x | clip_y;
    return res;
  endfunction

  always @(posedge clk) begin
    point_result_t want;
    point_result_t got;
    point_result_t fresh;
    if (rst) begin
      tension_q <= '0;
      bias_q <= '0;
      expected_points.delete();
      pending <= 0;
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TENSION: tension_q <= cfg_data;
          REG_BIAS:    bias_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fresh = predict_point(t_value, tension_q, bias_q,
                              longint'(p0_x), longint'(p0_y),
                              longint'(p1_x), longint'(p1_y),
                              longint'(p2_x), longint'(p2_y),
                              longint'(p3_x), longint'(p3_y));
        expected_points = {expected_points, fresh};
      end
      if (out_valid && !out_stall) begin
        got.x = out_x;
        got.y = out_y;
        got.sat = saturated;
        if (expected_points.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected word x=%0d y=%0d sat=%0b", $realtime,
                     got.x, got.y, got.sat);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: mismatch: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                       $realtime, want.x, want.y, want.sat, got.x, got.y, got.sat);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_points.size();
    end
  end

endmodule

// ===== verif/hermite_point_interpolator_tb.sv =====
`timescale 1ns / 1ps

module hermite_point_interpolator_tb;
  import hpi_pkg::*;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;

  localparam int NUM_PHASES       = 12;
  localparam int RANDOM_PER_PHASE = 90;
  localparam int DRAIN_CYCLES     = NUM_STAGES + 4;
  localparam int WATCHDOG_LIMIT   = 3000;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [FRAC_BITS+1:0] W_ZERO     = '0;
  localparam logic [FRAC_BITS+1:0] W_ONE      = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] W_NEG_ONE  = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] W_POS_RAIL = {2'b01, {FRAC_BITS{1'b1}}};
  localparam logic [FRAC_BITS+1:0] W_NEG_RAIL = {2'b10, {FRAC_BITS{1'b0}}};

  localparam logic [FRAC_BITS:0] T_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] T_TOP  = {(FRAC_BITS+1){1'b1}};
  localparam logic [FRAC_BITS:0] T_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  localparam int C_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int C_MIN = -(1 << (COORD_BITS - 1));

  typedef struct packed {
    logic [FRAC_BITS:0]           t_pos;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic signed [COORD_BITS-1:0] x3;
    logic signed [COORD_BITS-1:0] y3;
  } point_set_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [FRAC_BITS+1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [FRAC_BITS:0] t_value;
  logic signed [COORD_BITS-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  logic out_valid;
  logic out_stall;
  logic signed [COORD_BITS-1:0] out_x, out_y;
  logic saturated;

  int unsigned pending_count;
  int unsigned mismatch_count;
  int idle_cycles = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  hermite_point_interpolator #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .t_value(t_value),
    .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
    .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .saturated(saturated)
  );

  hermite_point_interpolator_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .t_value(t_value),
    .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
    .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .saturated(saturated),
    .pending(pending_count), .mismatches(mismatch_count)
  );

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** hermite_point_interpolator: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure: runs and stalls of random length, some long.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(1, 30);
        end
        4: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(100, 300);
        end
        5, 6, 7: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(1, 3);
        end
        8: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(4, 12);
        end
        default: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(20, 60);
        end
      endcase
    end
  end

  function automatic int sender_gap();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return 0;
      12, 13, 14, 15, 16: return $urandom_range(1, 3);
      17, 18: return $urandom_range(4, 15);
      default: return $urandom_range(20, 60);
    endcase
  endfunction

  function automatic logic [FRAC_BITS+1:0] random_weight();
    if ($urandom_range(0, 1))
      return (FRAC_BITS+2)'($urandom_range(0, 2 << FRAC_BITS) - (1 << FRAC_BITS));
    return (FRAC_BITS+2)'($urandom());
  endfunction

  // Coordinates come in as integers and wrap to the coordinate width.
  function automatic point_set_t mk_point(
      input logic [FRAC_BITS:0] t,
      input int a0, input int a1, input int a2, input int a3,
      input int b0, input int b1, input int b2, input int b3);
    point_set_t pt;
    pt.t_pos = t;
    pt.x0 = COORD_BITS'(a0); pt.x1 = COORD_BITS'(a1);
    pt.x2 = COORD_BITS'(a2); pt.x3 = COORD_BITS'(a3);
    pt.y0 = COORD_BITS'(b0); pt.y1 = COORD_BITS'(b1);
    pt.y2 = COORD_BITS'(b2); pt.y3 = COORD_BITS'(b3);
    return pt;
  endfunction

  function automatic point_set_t random_point();
    int c [8];
    int center;
    logic [FRAC_BITS:0] t;
    int spread;
    int style;
    int k;
    style = $urandom_range(0, 9);
    center = int'($urandom());
    spread = 1 << $urandom_range(4, 20);
    for (k = 0; k < 8; k++) begin
      case (style)
        // Points clustered like a real curve, so most results stay in range.
        0, 1, 2, 3, 4: c[k] = center + int'($urandom_range(0, 2 * spread)) - spread;
        5, 6: c[k] = int'($urandom());
        7: begin
          case ($urandom_range(0, 2))
            0: c[k] = C_MIN;
            1: c[k] = C_MAX;
            default: c[k] = 0;
          endcase
        end
        default: c[k] = int'($urandom_range(0, 511)) - 256;
      endcase
    end
    case ($urandom_range(0, 19))
      0: t = '0;
      1: t = T_ONE;
      2: t = (FRAC_BITS+1)'($urandom_range(T_ONE + 1, T_TOP));
      3: t = (FRAC_BITS+1)'($urandom_range(0, 15));
      4: t = (FRAC_BITS+1)'(T_ONE - $urandom_range(1, 15));
      default: t = (FRAC_BITS+1)'($urandom_range(0, T_ONE));
    endcase
    return mk_point(t, c[0], c[2], c[4], c[6], c[1], c[3], c[5], c[7]);
  endfunction

  // Holds the word until the block takes it; valid stays high afterwards.
  task automatic send_point(input point_set_t pt);
    in_valid <= 1'b1;
    t_value <= pt.t_pos;
    p0_x <= pt.x0; p0_y <= pt.y0;
    p1_x <= pt.x1; p1_y <= pt.y1;
    p2_x <= pt.x2; p2_y <= pt.y2;
    p3_x <= pt.x3; p3_y <= pt.y3;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      // Junk on the payload while valid is low must not matter.
      t_value <= (FRAC_BITS+1)'($urandom());
      p0_x <= COORD_BITS'($urandom());
      p1_y <= COORD_BITS'($urandom());
      p3_x <= COORD_BITS'($urandom());
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [FRAC_BITS+1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_point(mk_point('0, 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point(T_ONE, 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point(T_TOP, 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point((FRAC_BITS+1)'(T_ONE + 1), 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point(T_HALF, 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point(1, 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point((FRAC_BITS+1)'(T_ONE - 1), 'h10000, 'h30000, -'h20000, 'h58000,
                        -'h4000, 'h7000, 'h9000, -'h1000));
    send_point(mk_point(T_HALF, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_point(mk_point(T_HALF, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    // Overshoot past both rails: x clips high, y clips low.
    send_point(mk_point(T_HALF, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX));
    send_point(mk_point(T_ONE >> 2, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX));
    send_point(mk_point(T_HALF, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
    send_point(mk_point(T_HALF, 0, 0, 0, 0, 0, 0, 0, 0));
    send_point(mk_point(T_HALF, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN));
    // Halfway between -1 and +1 lsb lands on rounding ties.
    send_point(mk_point(T_HALF, -1, -1, 1, 1, 1, 1, -1, -1));
    send_point(mk_point(T_TOP, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX));
    idle_sender(1);
  endtask

  initial begin
    logic [FRAC_BITS+1:0] ten_w;
    logic [FRAC_BITS+1:0] bias_w;
    int phase;
    int n;
    bit gap_free;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    t_value <= '0;
    p0_x <= '0; p0_y <= '0; p1_x <= '0; p1_y <= '0;
    p2_x <= '0; p2_y <= '0; p3_x <= '0; p3_y <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // Registers change only with the pipeline empty.
      wait_quiet();
      case (phase)
        0: begin ten_w = W_ZERO; bias_w = W_ZERO; end
        1: begin ten_w = W_NEG_ONE; bias_w = W_ZERO; end
        2: begin ten_w = W_ONE; bias_w = W_ONE; end
        3: begin ten_w = W_ONE; bias_w = W_NEG_ONE; end
        4: begin ten_w = W_ZERO; bias_w = W_ONE; end
        5: begin ten_w = W_ZERO; bias_w = W_NEG_ONE; end
        6: begin ten_w = W_NEG_ONE; bias_w = W_NEG_ONE; end
        7: begin ten_w = W_NEG_ONE; bias_w = W_ONE; end
        8: begin ten_w = W_POS_RAIL; bias_w = W_NEG_RAIL; end
        9: begin ten_w = W_NEG_RAIL; bias_w = W_POS_RAIL; end
        default: begin ten_w = random_weight(); bias_w = random_weight(); end
      endcase
      write_reg(REG_TENSION, ten_w);
      write_reg(REG_BIAS, bias_w);
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                (FRAC_BITS+2)'($urandom()));
      cfg_valid <= 1'b0;
      @(posedge clk);
      if (phase == 0)
        run_directed();
      gap_free = ($urandom_range(0, 3) == 0);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_point(random_point());
        if (!gap_free)
          idle_sender(sender_gap());
      end
      in_valid <= 1'b0;
    end
    wait_quiet();
    if (mismatch_count == 0 && pending_count == 0)
      $display("** hermite_point_interpolator: PASSED **");
    else
      $display("** hermite_point_interpolator: FAILED **");
    $finish;
  end

endmodule
